// ----- src/ppt_pkg.sv -----
// ppt_pkg: shared widths, payload types and register indexes for the
// pose point transform. No dependencies; every other file uses it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package ppt_pkg;

   // field formats
   localparam int COORD_WIDTH    = 24;
   localparam int QUAT_FRAC_BITS = 14;
   localparam int QUAT_WIDTH     = QUAT_FRAC_BITS + 2;

   // internal widths
   localparam int T_WIDTH  = COORD_WIDTH + 1;            // translated point
   localparam int P1_WIDTH = T_WIDTH + QUAT_WIDTH;       // t * q product
   localparam int S1_WIDTH = P1_WIDTH + 2;               // sum of three products
   localparam int A_WIDTH  = COORD_WIDTH + 4;            // rounded first product
   localparam int P2_WIDTH = A_WIDTH + QUAT_WIDTH;       // q * a product
   localparam int S2_WIDTH = P2_WIDTH + 2;               // sum of four products
   localparam int W_WIDTH  = S2_WIDTH - QUAT_FRAC_BITS;  // rounded rotated point

   localparam int ROUND_HALF = 1 << (QUAT_FRAC_BITS - 1);
   localparam int COORD_MAX  = (1 << (COORD_WIDTH - 1)) - 1;
   localparam int COORD_MIN  = -(1 << (COORD_WIDTH - 1));

   // pipeline depth: translate, mul, sum, mul, sum, saturate
   localparam int NUM_STAGES = 6;

   // configuration port, data as wide as the widest register
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = (COORD_WIDTH > QUAT_WIDTH) ? COORD_WIDTH : QUAT_WIDTH;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_ROT_W   = 3'd0,
      REG_ROT_X   = 3'd1,
      REG_ROT_Y   = 3'd2,
      REG_ROT_Z   = 3'd3,
      REG_SHIFT_X = 3'd4,
      REG_SHIFT_Y = 3'd5,
      REG_SHIFT_Z = 3'd6
   } csr_index_type;

   // payload words
   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] point_x;
      logic signed [COORD_WIDTH-1:0] point_y;
      logic signed [COORD_WIDTH-1:0] point_z;
   } req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] out_x;
      logic signed [COORD_WIDTH-1:0] out_y;
      logic signed [COORD_WIDTH-1:0] out_z;
   } rsp_type;

   // pose
   typedef struct packed {
      logic signed [QUAT_WIDTH-1:0] w;
      logic signed [QUAT_WIDTH-1:0] x;
      logic signed [QUAT_WIDTH-1:0] y;
      logic signed [QUAT_WIDTH-1:0] z;
   } quat_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
      logic signed [COORD_WIDTH-1:0] z;
   } shift_type;

   // intermediate vectors
   typedef struct packed {
      logic signed [T_WIDTH-1:0] x;
      logic signed [T_WIDTH-1:0] y;
      logic signed [T_WIDTH-1:0] z;
   } t_vec_type;

   typedef struct packed {
      logic signed [A_WIDTH-1:0] w;
      logic signed [A_WIDTH-1:0] x;
      logic signed [A_WIDTH-1:0] y;
      logic signed [A_WIDTH-1:0] z;
   } a_quat_type;

   typedef struct packed {
      logic signed [W_WIDTH-1:0] x;
      logic signed [W_WIDTH-1:0] y;
      logic signed [W_WIDTH-1:0] z;
   } w_vec_type;

   // load enables for one product stage pair
   typedef struct packed {
      logic mul_en;
      logic sum_en;
   } stage_en_type;

endpackage

`default_nettype wire

// ----- src/ppt_quat_mul_a.sv -----
// ppt_quat_mul_a: first quaternion product a = t * q, one multiply stage and one
// rounding sum stage. Depends on ppt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppt_quat_mul_a (
   input  wire logic                 clock,
   input  wire ppt_pkg::stage_en_type en,
   input  wire ppt_pkg::quat_type     q,
   input  wire ppt_pkg::t_vec_type    t,
   output ppt_pkg::a_quat_type        a
);

   logic signed [ppt_pkg::P1_WIDTH-1:0] prod_ff [4][3];
   logic signed [ppt_pkg::S1_WIDTH-1:0] sum_in  [4];
   ppt_pkg::a_quat_type                 a_ff;

   // twelve partial products, grouped by result part
   always_ff @(posedge clock) begin
      if (en.mul_en) begin
         prod_ff[0][0] <= ppt_pkg::P1_WIDTH'(t.x) * ppt_pkg::P1_WIDTH'(q.x);
         prod_ff[0][1] <= ppt_pkg::P1_WIDTH'(t.y) * ppt_pkg::P1_WIDTH'(q.y);
         prod_ff[0][2] <= ppt_pkg::P1_WIDTH'(t.z) * ppt_pkg::P1_WIDTH'(q.z);
         prod_ff[1][0] <= ppt_pkg::P1_WIDTH'(t.x) * ppt_pkg::P1_WIDTH'(q.w);
         prod_ff[1][1] <= ppt_pkg::P1_WIDTH'(t.y) * ppt_pkg::P1_WIDTH'(q.z);
         prod_ff[1][2] <= ppt_pkg::P1_WIDTH'(t.z) * ppt_pkg::P1_WIDTH'(q.y);
         prod_ff[2][0] <= ppt_pkg::P1_WIDTH'(t.y) * ppt_pkg::P1_WIDTH'(q.w);
         prod_ff[2][1] <= ppt_pkg::P1_WIDTH'(t.z) * ppt_pkg::P1_WIDTH'(q.x);
         prod_ff[2][2] <= ppt_pkg::P1_WIDTH'(t.x) * ppt_pkg::P1_WIDTH'(q.z);
         prod_ff[3][0] <= ppt_pkg::P1_WIDTH'(t.z) * ppt_pkg::P1_WIDTH'(q.w);
         prod_ff[3][1] <= ppt_pkg::P1_WIDTH'(t.x) * ppt_pkg::P1_WIDTH'(q.y);
         prod_ff[3][2] <= ppt_pkg::P1_WIDTH'(t.y) * ppt_pkg::P1_WIDTH'(q.x);
      end
   end

   // signed sums plus rounding half
   always_comb begin
      sum_in[0] = ppt_pkg::S1_WIDTH'(ppt_pkg::ROUND_HALF)
                - ppt_pkg::S1_WIDTH'(prod_ff[0][0])
                - ppt_pkg::S1_WIDTH'(prod_ff[0][1])
                - ppt_pkg::S1_WIDTH'(prod_ff[0][2]);
      sum_in[1] = ppt_pkg::S1_WIDTH'(ppt_pkg::ROUND_HALF)
                + ppt_pkg::S1_WIDTH'(prod_ff[1][0])
                + ppt_pkg::S1_WIDTH'(prod_ff[1][1])
                - ppt_pkg::S1_WIDTH'(prod_ff[1][2]);
      sum_in[2] = ppt_pkg::S1_WIDTH'(ppt_pkg::ROUND_HALF)
                + ppt_pkg::S1_WIDTH'(prod_ff[2][0])
                + ppt_pkg::S1_WIDTH'(prod_ff[2][1])
                - ppt_pkg::S1_WIDTH'(prod_ff[2][2]);
      sum_in[3] = ppt_pkg::S1_WIDTH'(ppt_pkg::ROUND_HALF)
                + ppt_pkg::S1_WIDTH'(prod_ff[3][0])
                + ppt_pkg::S1_WIDTH'(prod_ff[3][1])
                - ppt_pkg::S1_WIDTH'(prod_ff[3][2]);
   end

   // drop fraction bits, result always fits
   always_ff @(posedge clock) begin
      if (en.sum_en) begin
         a_ff.w <= sum_in[0][ppt_pkg::A_WIDTH+ppt_pkg::QUAT_FRAC_BITS-1:ppt_pkg::QUAT_FRAC_BITS];
         a_ff.x <= sum_in[1][ppt_pkg::A_WIDTH+ppt_pkg::QUAT_FRAC_BITS-1:ppt_pkg::QUAT_FRAC_BITS];
         a_ff.y <= sum_in[2][ppt_pkg::A_WIDTH+ppt_pkg::QUAT_FRAC_BITS-1:ppt_pkg::QUAT_FRAC_BITS];
         a_ff.z <= sum_in[3][ppt_pkg::A_WIDTH+ppt_pkg::QUAT_FRAC_BITS-1:ppt_pkg::QUAT_FRAC_BITS];
      end
   end

   assign a = a_ff;

endmodule

`default_nettype wire

// ----- src/ppt_quat_mul_w.sv -----
// ppt_quat_mul_w: second quaternion product w = conj(q) * a, vector part only,
// one multiply stage and one rounding sum stage. Depends on ppt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppt_quat_mul_w (
   input  wire logic                  clock,
   input  wire ppt_pkg::stage_en_type  en,
   input  wire ppt_pkg::quat_type      q,
   input  wire ppt_pkg::a_quat_type    a,
   output ppt_pkg::w_vec_type          w
);

   logic signed [ppt_pkg::P2_WIDTH-1:0] prod_ff [3][4];
   logic signed [ppt_pkg::S2_WIDTH-1:0] sum_in  [3];
   ppt_pkg::w_vec_type                  w_ff;

   // sixteen products less the unused real part: twelve
   always_ff @(posedge clock) begin
      if (en.mul_en) begin
         prod_ff[0][0] <= ppt_pkg::P2_WIDTH'(q.w) * ppt_pkg::P2_WIDTH'(a.x);
         prod_ff[0][1] <= ppt_pkg::P2_WIDTH'(q.x) * ppt_pkg::P2_WIDTH'(a.w);
         prod_ff[0][2] <= ppt_pkg::P2_WIDTH'(q.y) * ppt_pkg::P2_WIDTH'(a.z);
         prod_ff[0][3] <= ppt_pkg::P2_WIDTH'(q.z) * ppt_pkg::P2_WIDTH'(a.y);
         prod_ff[1][0] <= ppt_pkg::P2_WIDTH'(q.w) * ppt_pkg::P2_WIDTH'(a.y);
         prod_ff[1][1] <= ppt_pkg::P2_WIDTH'(q.y) * ppt_pkg::P2_WIDTH'(a.w);
         prod_ff[1][2] <= ppt_pkg::P2_WIDTH'(q.z) * ppt_pkg::P2_WIDTH'(a.x);
         prod_ff[1][3] <= ppt_pkg::P2_WIDTH'(q.x) * ppt_pkg::P2_WIDTH'(a.z);
         prod_ff[2][0] <= ppt_pkg::P2_WIDTH'(q.w) * ppt_pkg::P2_WIDTH'(a.z);
         prod_ff[2][1] <= ppt_pkg::P2_WIDTH'(q.z) * ppt_pkg::P2_WIDTH'(a.w);
         prod_ff[2][2] <= ppt_pkg::P2_WIDTH'(q.x) * ppt_pkg::P2_WIDTH'(a.y);
         prod_ff[2][3] <= ppt_pkg::P2_WIDTH'(q.y) * ppt_pkg::P2_WIDTH'(a.x);
      end
   end

   // same sign pattern for every axis: + - - +
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum_in[i] = ppt_pkg::S2_WIDTH'(ppt_pkg::ROUND_HALF)
                   + ppt_pkg::S2_WIDTH'(prod_ff[i][0])
                   - ppt_pkg::S2_WIDTH'(prod_ff[i][1])
                   - ppt_pkg::S2_WIDTH'(prod_ff[i][2])
                   + ppt_pkg::S2_WIDTH'(prod_ff[i][3]);
      end
   end

   // drop fraction bits
   always_ff @(posedge clock) begin
      if (en.sum_en) begin
         w_ff.x <= sum_in[0][ppt_pkg::S2_WIDTH-1:ppt_pkg::QUAT_FRAC_BITS];
         w_ff.y <= sum_in[1][ppt_pkg::S2_WIDTH-1:ppt_pkg::QUAT_FRAC_BITS];
         w_ff.z <= sum_in[2][ppt_pkg::S2_WIDTH-1:ppt_pkg::QUAT_FRAC_BITS];
      end
   end

   assign w = w_ff;

endmodule

`default_nettype wire

// ----- src/pose_point_transform.sv -----
//  channel  | direction | handshake            | word
//  req      | in        | req_valid/req_stall  | ppt_pkg::req_type (point_x/y/z)
//  rsp      | out       | rsp_valid/rsp_stall  | ppt_pkg::rsp_type (out_x/y/z)
//  csr      | in        | csr_we               | csr_index, csr_wdata (pose)
//
//  One word per cycle unless rsp_stall holds the pipeline; stages: translate,
//  t*q multiply, sum, conj(q)*a multiply, sum, saturate into the output register.
//  The two multiply stages (twelve multipliers each) set the cycle time.
//  Reset clears all valid bits and loads the identity pose.
//  Each stage loads when it is empty or its successor moves, so a stall on
//  rsp reaches req_stall only once every stage holds a word.
// pose_point_transform: top level, pose registers, translation, saturation and
// pipeline control. Depends on ppt_pkg, ppt_quat_mul_a, ppt_quat_mul_w.
`timescale 1ns / 1ps
`default_nettype none

module pose_point_transform (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire ppt_pkg::req_type                     req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output ppt_pkg::rsp_type                          rsp_data,
   input  wire logic                                 csr_we,
   input  wire logic [ppt_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [ppt_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   ppt_pkg::quat_type                   rot_ff;
   ppt_pkg::shift_type                  shift_ff;
   logic [ppt_pkg::NUM_STAGES-1:0]      valid_ff;
   logic [ppt_pkg::NUM_STAGES-1:0]      valid_in;
   logic [ppt_pkg::NUM_STAGES-1:0]      rdy;
   ppt_pkg::t_vec_type                  t_ff;
   ppt_pkg::a_quat_type                 a_vec;
   ppt_pkg::w_vec_type                  w_vec;
   ppt_pkg::stage_en_type               en_a;
   ppt_pkg::stage_en_type               en_w;
   ppt_pkg::rsp_type                    out_ff;
   ppt_pkg::rsp_type                    out_in;

   // pose registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff   <= '{w: ppt_pkg::QUAT_WIDTH'(1 << ppt_pkg::QUAT_FRAC_BITS),
                       x: '0, y: '0, z: '0};
         shift_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            ppt_pkg::REG_ROT_W:   rot_ff.w   <= csr_wdata[ppt_pkg::QUAT_WIDTH-1:0];
            ppt_pkg::REG_ROT_X:   rot_ff.x   <= csr_wdata[ppt_pkg::QUAT_WIDTH-1:0];
            ppt_pkg::REG_ROT_Y:   rot_ff.y   <= csr_wdata[ppt_pkg::QUAT_WIDTH-1:0];
            ppt_pkg::REG_ROT_Z:   rot_ff.z   <= csr_wdata[ppt_pkg::QUAT_WIDTH-1:0];
            ppt_pkg::REG_SHIFT_X: shift_ff.x <= csr_wdata[ppt_pkg::COORD_WIDTH-1:0];
            ppt_pkg::REG_SHIFT_Y: shift_ff.y <= csr_wdata[ppt_pkg::COORD_WIDTH-1:0];
            ppt_pkg::REG_SHIFT_Z: shift_ff.z <= csr_wdata[ppt_pkg::COORD_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // ready chain from the output back to the input
   always_comb begin
      rdy[ppt_pkg::NUM_STAGES-1] = !valid_ff[ppt_pkg::NUM_STAGES-1] || !rsp_stall;
      for (int i = ppt_pkg::NUM_STAGES - 2; i >= 0; i--) begin
         rdy[i] = !valid_ff[i] || rdy[i+1];
      end
   end

   // valid bits travel with the words
   always_comb begin
      for (int i = 0; i < ppt_pkg::NUM_STAGES; i++) begin
         if (rdy[i]) begin
            valid_in[i] = (i == 0) ? req_valid : valid_ff[(i == 0) ? 0 : i - 1];
         end else begin
            valid_in[i] = valid_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !rdy[0];

   // translate
   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         t_ff.x <= ppt_pkg::T_WIDTH'(req_data.point_x) + ppt_pkg::T_WIDTH'(shift_ff.x);
         t_ff.y <= ppt_pkg::T_WIDTH'(req_data.point_y) + ppt_pkg::T_WIDTH'(shift_ff.y);
         t_ff.z <= ppt_pkg::T_WIDTH'(req_data.point_z) + ppt_pkg::T_WIDTH'(shift_ff.z);
      end
   end

   assign en_a = '{mul_en: rdy[1], sum_en: rdy[2]};
   assign en_w = '{mul_en: rdy[3], sum_en: rdy[4]};

   ppt_quat_mul_a u_mul_a (
      .clock (clock),
      .en    (en_a),
      .q     (rot_ff),
      .t     (t_ff),
      .a     (a_vec)
   );

   ppt_quat_mul_w u_mul_w (
      .clock (clock),
      .en    (en_w),
      .q     (rot_ff),
      .a     (a_vec),
      .w     (w_vec)
   );

   // saturate to the coordinate range
   always_comb begin
      if (w_vec.x > ppt_pkg::W_WIDTH'(ppt_pkg::COORD_MAX)) begin
         out_in.out_x = ppt_pkg::COORD_WIDTH'(ppt_pkg::COORD_MAX);
      end else if (w_vec.x < ppt_pkg::W_WIDTH'(ppt_pkg::COORD_MIN)) begin
         out_in.out_x = ppt_pkg::COORD_WIDTH'(ppt_pkg::COORD_MIN);
      end else begin
         out_in.out_x = w_vec.x[ppt_pkg::COORD_WIDTH-1:0];
      end
      if (w_vec.y > ppt_pkg::W_WIDTH'(ppt_pkg::COORD_MAX)) begin
         out_in.out_y = ppt_pkg::COORD_WIDTH'(ppt_pkg::COORD_MAX);
      end else if (w_vec.y < ppt_pkg::W_WIDTH'(ppt_pkg::COORD_MIN)) begin
         out_in.out_y = ppt_pkg::COORD_WIDTH'(ppt_pkg::COORD_MIN);
      end else begin
         out_in.out_y = w_vec.y[ppt_pkg::COORD_WIDTH-1:0];
      end
      if (w_vec.z > ppt_pkg::W_WIDTH'(ppt_pkg::COORD_MAX)) begin
         out_in.out_z = ppt_pkg::COORD_WIDTH'(ppt_pkg::COORD_MAX);
      end else if (w_vec.z < ppt_pkg::W_WIDTH'(ppt_pkg::COORD_MIN)) begin
         out_in.out_z = ppt_pkg::COORD_WIDTH'(ppt_pkg::COORD_MIN);
      end else begin
         out_in.out_z = w_vec.z[ppt_pkg::COORD_WIDTH-1:0];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (rdy[ppt_pkg::NUM_STAGES-1]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = valid_ff[ppt_pkg::NUM_STAGES-1];
   assign rsp_data  = out_ff;

   // input stalls only when every stage holds a word
   a_full_on_stall : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&valid_ff))
      else $error("req_stall raised with a free pipeline stage");

   // a free output side never pushes back on the input
   a_no_stall_when_drained : assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("req_stall raised while rsp side is taking words");

   // taking the last word with nothing behind it empties the output
   a_output_drains : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !valid_ff[ppt_pkg::NUM_STAGES-2]) |=> !rsp_valid)
      else $error("output word repeated after being taken");

   // reset leaves the pipeline empty
   a_reset_empty : assert property (@(posedge clock)
      reset |=> (valid_ff == '0))
      else $error("valid bits set right after reset");

endmodule

`default_nettype wire
